/* hdl/vrc_pkg.sv */
// vrc_pkg: shared types and sizes for the vertical rectangle coalescer
`default_nettype none
package vrc_pkg;

  // table size
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // input word: one rectangle
  typedef struct packed {
    logic [15:0] rect_left;
    logic [15:0] rect_top;
    logic [15:0] rect_right;
    logic [15:0] rect_bottom;
    logic        last_rect;
  } in_item_t;

  // result word: one coalesced rectangle
  typedef struct packed {
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_right;
    logic [15:0] out_bottom;
    logic        out_last;
    logic        table_overflowed;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
  } rect_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

/* hdl/vertical_rect_coalescer_top.sv */
// vertical_rect_coalescer_top: rectangle table with vertical merge and list dump
//
//   channel | ports                      | handshake
//   --------+----------------------------+------------------------------------
//   input   | start, busy, in_item       | word taken when start & !busy
//   result  | out_strobe, out_item       | word valid for one cycle on strobe
//
// An input word holds busy through the scan: one entry read per cycle on the single
// read port, then the last compare, a drain step and the append. A last_rect word
// then dumps one word per cycle and holds busy until the dump is done.
// Reset (rst_n low, synchronous) empties the table and clears the overflow flag.
// The receiver cannot stall; results go out back to back during the dump.
`default_nettype none
module vertical_rect_coalescer_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire vrc_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output vrc_pkg::out_item_t      out_item
);
  import vrc_pkg::*;

  // table memory
  rect_t mem [TABLE_DEPTH];
  rect_t rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rect_t            wr_data;

  // control and held input
  state_t           state_r, state_nxt;
  rect_t            rect_r, rect_nxt;
  logic             last_r, last_nxt;
  logic             joined_r, joined_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic accept;
  logic issue_done;
  logic match;
  logic [16:0] w_e, w_r;
  logic touch, edge_eq;
  rect_t merged;

  assign accept     = start && (state_r == ST_IDLE);
  assign issue_done = (issue_r == count_r);

  // match test of the entry just read against the held rectangle
  always_comb begin
    w_e     = {1'b0, rd_data_r.right} - {1'b0, rd_data_r.left};
    w_r     = {1'b0, rect_r.right} - {1'b0, rect_r.left};
    touch   = (({1'b0, rd_data_r.bottom} + 17'd1) == {1'b0, rect_r.top}) ||
              ({1'b0, rd_data_r.top} == ({1'b0, rect_r.bottom} + 17'd1));
    edge_eq = (rd_data_r.left == rect_r.left) || (rd_data_r.right == rect_r.right);
    match   = touch && edge_eq && (w_e == w_r);
    merged.left   = (rd_data_r.left   < rect_r.left)   ? rd_data_r.left   : rect_r.left;
    merged.top    = (rd_data_r.top    < rect_r.top)    ? rd_data_r.top    : rect_r.top;
    merged.right  = (rd_data_r.right  > rect_r.right)  ? rd_data_r.right  : rect_r.right;
    merged.bottom = (rd_data_r.bottom > rect_r.bottom) ? rd_data_r.bottom : rect_r.bottom;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (issue_done && !cmp_vld_r) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (issue_done && !cmp_vld_r) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = issue_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = cmp_idx_r;
    wr_data     = merged;
    rect_nxt    = rect_r;
    last_nxt    = last_r;
    joined_nxt  = joined_r;
    ovf_nxt     = ovf_r;
    count_nxt   = count_r;
    issue_nxt   = issue_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rect_nxt   = '{left: in_item.rect_left, top: in_item.rect_top,
                         right: in_item.rect_right, bottom: in_item.rect_bottom};
          last_nxt   = in_item.last_rect;
          joined_nxt = 1'b0;
          issue_nxt  = '0;
        end
      end
      ST_SCAN: begin
        // walk the table, merge in place in the cycle after each read
        if (!issue_done) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end
        if (cmp_vld_r && match) begin
          wr_en      = 1'b1;
          joined_nxt = 1'b1;
        end
      end
      ST_FINISH: begin
        // append when nothing merged, or flag the drop if the table is full
        if (!joined_r) begin
          if (count_r < CNT_W'(TABLE_DEPTH)) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[IDX_W-1:0];
            wr_data   = rect_r;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        issue_nxt = '0;
      end
      ST_EMIT: begin
        // dump entries in order, then empty the table and clear the overflow flag
        if (!issue_done) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + CNT_W'(1);
        end else if (!cmp_vld_r) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // table memory ports
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    rect_r    <= rect_nxt;
    last_r    <= last_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      joined_r  <= 1'b0;
      ovf_r     <= 1'b0;
      count_r   <= '0;
      issue_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      joined_r  <= joined_nxt;
      ovf_r     <= ovf_nxt;
      count_r   <= count_nxt;
      issue_r   <= issue_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  // handshake and result outputs
  always_comb begin
    busy                      = (state_r != ST_IDLE);
    out_strobe                = (state_r == ST_EMIT) && cmp_vld_r;
    out_item.out_left         = rd_data_r.left;
    out_item.out_top          = rd_data_r.top;
    out_item.out_right        = rd_data_r.right;
    out_item.out_bottom       = rd_data_r.bottom;
    out_item.out_last         = ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == count_r);
    out_item.table_overflowed = ovf_r;
  end

  // checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result word while idle");
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr)) else $error("read and write same entry");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH)) else $error("entry count beyond table");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.out_last) |=> !out_strobe) else $error("word after last");

endmodule
`default_nettype wire
